### rtl/urtb_pkg.sv
package urtb_pkg;

    // Buffer depths; each ring keeps one slot empty.
    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);

    // Field widths of the request and result.
    localparam int CMD_W   = 3;
    localparam int DATA_W  = 8;
    localparam int BLEN_W  = 7;
    localparam int COUNT_W = 6;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE  = 3'd0,
        CMD_READ     = 3'd1,
        CMD_PUT      = 3'd2,
        CMD_BURST    = 3'd3,
        CMD_TX_READY = 3'd4,
        CMD_RX_FLUSH = 3'd5,
        CMD_RESET    = 3'd6
    } cmd_e_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data_in;
        logic              burst_first;
        logic [BLEN_W-1:0] burst_len;
    } urtb_in_t;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  data_out;
        logic [COUNT_W-1:0] rx_count;
        logic [COUNT_W-1:0] tx_pending;
        logic [COUNT_W-1:0] tx_free;
        logic               tx_active;
    } urtb_out_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_load;
        logic exec;
        logic out_load;
    } ctl_cmd_t;

endpackage

### rtl/urtb_ram.sv
module urtb_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/urtb_ctrl.sv
module urtb_ctrl
    import urtb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ctl_cmd_t ctl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands to the datapath.
    always_comb begin
        state_next   = state_reg;
        ctl          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.in_load = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

### rtl/urtb_datapath.sv
module urtb_datapath
    import urtb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ctl_cmd_t  ctl,
    input  urtb_in_t  s_data,
    output urtb_out_t m_data
);

    localparam int CMP_W = ((BLEN_W > TX_PTR_W) ? BLEN_W : TX_PTR_W) + 1;

    urtb_in_t            in_reg;
    urtb_out_t           out_reg, out_next;
    logic [RX_PTR_W-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RX_PTR_W-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [TX_PTR_W-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [TX_PTR_W-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic                tx_en_reg, tx_en_next;
    logic                burst_acc_reg, burst_acc_next;
    logic                ok_reg, ok_next;
    logic                pop_rx_reg, pop_rx_next;
    logic                pop_tx_reg, pop_tx_next;

    logic [RX_PTR_W-1:0] rx_wr_adv, rx_rd_adv, rx_used;
    logic [TX_PTR_W-1:0] tx_wr_adv, tx_rd_adv, tx_used, tx_room;
    logic                rx_full, rx_empty, tx_full, tx_empty;
    logic                rx_we, tx_we, push_req;
    logic [DATA_W-1:0]   rx_rdata, tx_rdata;

    // Pointer advance with wrap, and fill levels.
    always_comb begin
        rx_wr_adv = (rx_wr_ptr_reg == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr_reg + 1'b1;
        rx_rd_adv = (rx_rd_ptr_reg == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr_reg + 1'b1;
        tx_wr_adv = (tx_wr_ptr_reg == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr_reg + 1'b1;
        tx_rd_adv = (tx_rd_ptr_reg == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr_reg + 1'b1;
        rx_full   = (rx_wr_adv == rx_rd_ptr_reg);
        tx_full   = (tx_wr_adv == tx_rd_ptr_reg);
        rx_empty  = (rx_wr_ptr_reg == rx_rd_ptr_reg);
        tx_empty  = (tx_wr_ptr_reg == tx_rd_ptr_reg);
        rx_used   = (rx_wr_ptr_reg >= rx_rd_ptr_reg) ? (rx_wr_ptr_reg - rx_rd_ptr_reg)
                  : (RX_PTR_W'(RX_DEPTH) - (rx_rd_ptr_reg - rx_wr_ptr_reg));
        tx_used   = (tx_wr_ptr_reg >= tx_rd_ptr_reg) ? (tx_wr_ptr_reg - tx_rd_ptr_reg)
                  : (TX_PTR_W'(TX_DEPTH) - (tx_rd_ptr_reg - tx_wr_ptr_reg));
        tx_room   = TX_PTR_W'(TX_DEPTH - 1) - tx_used;
    end

    // Command execution: pointer updates, flags and store writes.
    always_comb begin
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        tx_wr_ptr_next = tx_wr_ptr_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        tx_en_next     = tx_en_reg;
        burst_acc_next = burst_acc_reg;
        ok_next        = ok_reg;
        pop_rx_next    = pop_rx_reg;
        pop_tx_next    = pop_tx_reg;
        rx_we          = 1'b0;
        push_req       = 1'b0;
        if (ctl.exec) begin
            ok_next     = 1'b0;
            pop_rx_next = 1'b0;
            pop_tx_next = 1'b0;
            case (in_reg.cmd)
                CMD_RX_BYTE: begin
                    if (!rx_full) begin
                        rx_we          = 1'b1;
                        rx_wr_ptr_next = rx_wr_adv;
                        ok_next        = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (!rx_empty) begin
                        rx_rd_ptr_next = rx_rd_adv;
                        pop_rx_next    = 1'b1;
                        ok_next        = 1'b1;
                    end
                end
                CMD_PUT: begin
                    push_req = 1'b1;
                end
                CMD_BURST: begin
                    // The first element decides for the whole burst.
                    if (in_reg.burst_first) begin
                        burst_acc_next = (CMP_W'(in_reg.burst_len) <= CMP_W'(tx_room));
                    end
                    push_req = burst_acc_next;
                end
                CMD_TX_READY: begin
                    if (!tx_empty) begin
                        tx_rd_ptr_next = tx_rd_adv;
                        pop_tx_next    = 1'b1;
                        ok_next        = 1'b1;
                    end else begin
                        tx_en_next = 1'b0;
                    end
                end
                CMD_RX_FLUSH: begin
                    rx_wr_ptr_next = '0;
                    rx_rd_ptr_next = '0;
                end
                CMD_RESET: begin
                    rx_wr_ptr_next = '0;
                    rx_rd_ptr_next = '0;
                    tx_wr_ptr_next = '0;
                    tx_rd_ptr_next = '0;
                    tx_en_next     = 1'b0;
                    burst_acc_next = 1'b0;
                end
                default: begin
                end
            endcase
            // Shared transmit push for single puts and burst elements.
            if (push_req && !tx_full) begin
                tx_wr_ptr_next = tx_wr_adv;
                tx_en_next     = 1'b1;
                ok_next        = 1'b1;
            end
        end
        tx_we = ctl.exec && push_req && !tx_full;
    end

    // Result composed from the state after the command.
    always_comb begin
        out_next.ok         = ok_reg;
        out_next.data_out   = pop_rx_reg ? rx_rdata : (pop_tx_reg ? tx_rdata : '0);
        out_next.rx_count   = COUNT_W'(rx_used);
        out_next.tx_pending = COUNT_W'(tx_used);
        out_next.tx_free    = COUNT_W'(tx_room);
        out_next.tx_active  = tx_en_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_ptr_reg <= '0;
            rx_rd_ptr_reg <= '0;
            tx_wr_ptr_reg <= '0;
            tx_rd_ptr_reg <= '0;
            tx_en_reg     <= 1'b0;
            burst_acc_reg <= 1'b0;
            ok_reg        <= 1'b0;
            pop_rx_reg    <= 1'b0;
            pop_tx_reg    <= 1'b0;
        end else begin
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            tx_en_reg     <= tx_en_next;
            burst_acc_reg <= burst_acc_next;
            ok_reg        <= ok_next;
            pop_rx_reg    <= pop_rx_next;
            pop_tx_reg    <= pop_tx_next;
        end
    end

    // Payload registers for the request and the result.
    always_ff @(posedge aclk) begin
        if (ctl.in_load) begin
            in_reg <= s_data;
        end
        if (ctl.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // Receive and transmit stores.
    urtb_ram #(
        .DEPTH (RX_DEPTH),
        .WIDTH (DATA_W)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_wr_ptr_reg),
        .wdata (in_reg.data_in),
        .re    (ctl.exec),
        .raddr (rx_rd_ptr_reg),
        .rdata (rx_rdata)
    );

    urtb_ram #(
        .DEPTH (TX_DEPTH),
        .WIDTH (DATA_W)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_wr_ptr_reg),
        .wdata (in_reg.data_in),
        .re    (ctl.exec),
        .raddr (tx_rd_ptr_reg),
        .rdata (tx_rdata)
    );

    // A reset command empties both rings and clears the flags.
    a_reset_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.exec && in_reg.cmd == CMD_RESET) |=>
        (tx_wr_ptr_reg == '0 && tx_rd_ptr_reg == '0 && rx_wr_ptr_reg == '0
         && !tx_en_reg && !burst_acc_reg))
        else $error("reset command left state behind");

    // A stored transmit byte always raises the active flag.
    a_push_sets_active: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_we |=> (tx_en_reg && ok_reg))
        else $error("transmit push did not set active flag");

    // Transmitter ready on an empty ring clears the flag and reports failure.
    a_tx_empty_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.exec && in_reg.cmd == CMD_TX_READY && tx_empty) |=>
        (!tx_en_reg && !ok_reg && !pop_tx_reg))
        else $error("transmitter ready on empty ring misbehaved");

endmodule

### rtl/uart_rx_tx_ring_buffers_top.sv
// Channel   Ports                        Payload
// request   s_valid, s_ready, s_data     urtb_in_t  (cmd, data_in, burst_first, burst_len)
// result    m_valid, m_ready, m_data     urtb_out_t (ok, data_out, counts, tx_active)
//
// Each request passes through accept, execute (pointer update and one store
// access in each ring's RAM), and result load into the output register.
// One result per request, in order; a new request is accepted while a result waits.
// A stalled result holds the next result load and so the request port; the rings keep their state.
// aresetn is synchronous, active low, and clears pointers and flags; store contents
// are not cleared.
module uart_rx_tx_ring_buffers_top
    import urtb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  urtb_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output urtb_out_t m_data
);

    ctl_cmd_t ctl;

    // Sequencing of each request.
    urtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // Ring pointers, stores and result register.
    urtb_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

### bench/tb_top.sv
module tb_top
    import urtb_pkg::*;
;

    // Receiver hold-off that backs the block up into its request port.
    localparam int LONG_HOLD = 150;

    // Kinds of random traffic; all but MIXED are biased toward one corner of the rings.
    typedef enum {
        FILL_RX,
        FILL_TX,
        DRAIN,
        MIXED
    } mix_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    urtb_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    urtb_out_t m_data;

    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    int sent_items   = 0;

    // Tracks both rings and the burst decision, and queues the result each request should give.
    class ring_tracker_t;
        logic [DATA_W-1:0] rx_ring [RX_DEPTH];
        logic [DATA_W-1:0] tx_ring [TX_DEPTH];
        int rx_wr, rx_rd, tx_wr, tx_rd;
        bit tx_on;
        bit burst_open;
        urtb_out_t due [$];
        int mismatches;

        function int ring_used(int wr, int rd, int depth);
            return (wr >= rd) ? wr - rd : depth - (rd - wr);
        endfunction

        function int next_slot(int p, int depth);
            return (p + 1 >= depth) ? 0 : p + 1;
        endfunction

        function int tx_room();
            return TX_DEPTH - 1 - ring_used(tx_wr, tx_rd, TX_DEPTH);
        endfunction

        function bit tx_push(logic [DATA_W-1:0] b);
            if (next_slot(tx_wr, TX_DEPTH) == tx_rd) begin
                return 1'b0;
            end
            tx_ring[tx_wr] = b;
            tx_wr = next_slot(tx_wr, TX_DEPTH);
            tx_on = 1'b1;
            return 1'b1;
        endfunction

        // Applies one accepted request to the rings and queues its result.
        function void apply_request(urtb_in_t req);
            urtb_out_t want;
            want = '0;
            case (req.cmd)
                CMD_RX_BYTE: begin
                    if (next_slot(rx_wr, RX_DEPTH) != rx_rd) begin
                        rx_ring[rx_wr] = req.data_in;
                        rx_wr = next_slot(rx_wr, RX_DEPTH);
                        want.ok = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (rx_wr != rx_rd) begin
                        want.data_out = rx_ring[rx_rd];
                        rx_rd = next_slot(rx_rd, RX_DEPTH);
                        want.ok = 1'b1;
                    end
                end
                CMD_PUT: begin
                    want.ok = tx_push(req.data_in);
                end
                CMD_BURST: begin
                    // The first element decides for the whole burst and for any strays after it.
                    if (req.burst_first) begin
                        burst_open = (int'(req.burst_len) <= tx_room());
                    end
                    if (burst_open) begin
                        want.ok = tx_push(req.data_in);
                    end
                end
                CMD_TX_READY: begin
                    if (tx_wr != tx_rd) begin
                        want.data_out = tx_ring[tx_rd];
                        tx_rd = next_slot(tx_rd, TX_DEPTH);
                        want.ok = 1'b1;
                    end else begin
                        tx_on = 1'b0;
                    end
                end
                CMD_RX_FLUSH: begin
                    rx_wr = 0;
                    rx_rd = 0;
                end
                CMD_RESET: begin
                    rx_wr = 0;
                    rx_rd = 0;
                    tx_wr = 0;
                    tx_rd = 0;
                    tx_on = 1'b0;
                    burst_open = 1'b0;
                end
                default: ;
            endcase
            want.rx_count   = COUNT_W'(ring_used(rx_wr, rx_rd, RX_DEPTH));
            want.tx_pending = COUNT_W'(ring_used(tx_wr, tx_rd, TX_DEPTH));
            want.tx_free    = COUNT_W'(tx_room());
            want.tx_active  = tx_on;
            due.push_back(want);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on %s: expected %0h, got %0h", name, want, got);
                end
            end
        endfunction

        // Compares one accepted result with the oldest queued one.
        function void compare_result(urtb_out_t got);
            urtb_out_t want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result %h with nothing outstanding", got);
                end
                return;
            end
            want = due.pop_front();
            check_field("ok", 8'(want.ok), 8'(got.ok));
            check_field("data_out", want.data_out, got.data_out);
            check_field("rx_count", 8'(want.rx_count), 8'(got.rx_count));
            check_field("tx_pending", 8'(want.tx_pending), 8'(got.tx_pending));
            check_field("tx_free", 8'(want.tx_free), 8'(got.tx_free));
            check_field("tx_active", 8'(want.tx_active), 8'(got.tx_active));
        endfunction
    endclass

    ring_tracker_t book = new();

    uart_rx_tx_ring_buffers_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Both channels are sampled on the edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                book.apply_request(s_data);
            end
            if (m_valid && m_ready) begin
                book.compare_result(m_data);
            end
        end
    end

    // Result side: random ready bursts and stalls, plus one long hold-off on request.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    function automatic urtb_in_t make_request(cmd_e_t c, logic [DATA_W-1:0] d, logic f,
                                              logic [BLEN_W-1:0] len);
        urtb_in_t r;
        r.cmd         = c;
        r.data_in     = d;
        r.burst_first = f;
        r.burst_len   = len;
        return r;
    endfunction

    function automatic cmd_e_t any_data_cmd();
        case ($urandom_range(0, 3))
            0:       return CMD_RX_BYTE;
            1:       return CMD_READ;
            2:       return CMD_PUT;
            default: return CMD_TX_READY;
        endcase
    endfunction

    // Offers one request and returns on the edge that accepts it, with valid left high.
    task automatic send_request(input urtb_in_t req);
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic send_loose(input cmd_e_t c);
        send_request(make_request(c, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                                  BLEN_W'($urandom_range(1, 64))));
    endtask

    // A burst write; some run past or stop short of the announced length.
    task automatic send_burst();
        int announced;
        int total;
        announced = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        total = announced;
        case ($urandom_range(0, 9))
            0, 1:    total = announced + $urandom_range(1, 4);
            2:       total = $urandom_range(1, announced);
            default: ;
        endcase
        send_request(make_request(CMD_BURST, DATA_W'($urandom), 1'b1, BLEN_W'(announced)));
        for (int k = 1; k < total; k++) begin
            send_request(make_request(CMD_BURST, DATA_W'($urandom), 1'b0,
                                      BLEN_W'($urandom_range(1, 64))));
        end
    endtask

    task automatic run_segment(input mix_t mix, input int count);
        int stop;
        int roll;
        stop = sent_items + count;
        while (sent_items < stop) begin
            roll = $urandom_range(0, 99);
            case (mix)
                FILL_RX: begin
                    if (roll < 90) send_loose(CMD_RX_BYTE);
                    else if (roll < 95) send_loose(CMD_READ);
                    else send_loose(any_data_cmd());
                end
                FILL_TX: begin
                    if (roll < 50) send_loose(CMD_PUT);
                    else if (roll < 85) send_burst();
                    else send_loose(any_data_cmd());
                end
                DRAIN: begin
                    if (roll < 45) send_loose(CMD_READ);
                    else if (roll < 90) send_loose(CMD_TX_READY);
                    else send_loose(any_data_cmd());
                end
                default: begin
                    if (roll < 20) send_burst();
                    else send_loose(cmd_e_t'(CMD_W'($urandom_range(0, 6))));
                end
            endcase
        end
    endtask

    // Stops offering and waits until every queued result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (book.due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // A stray burst element right after reset is dropped.
        send_request(make_request(CMD_BURST, 8'hA5, 1'b0, 7'd5));
        // Receive side: extreme bytes, reads, then a read of an empty ring.
        send_request(make_request(CMD_RX_BYTE, 8'h00, 1'b0, 7'd1));
        send_request(make_request(CMD_RX_BYTE, 8'hFF, 1'b1, 7'd64));
        send_request(make_request(CMD_READ, 8'h00, 1'b0, 7'd1));
        send_request(make_request(CMD_READ, 8'h00, 1'b0, 7'd1));
        send_request(make_request(CMD_READ, 8'h00, 1'b0, 7'd1));
        // Transmitter ready on an empty ring while inactive.
        send_request(make_request(CMD_TX_READY, 8'h00, 1'b0, 7'd1));
        send_request(make_request(CMD_PUT, 8'hFF, 1'b0, 7'd1));
        send_request(make_request(CMD_PUT, 8'h00, 1'b0, 7'd1));
        // A burst too long for the free space is refused, and so is the element after it.
        send_request(make_request(CMD_BURST, 8'h55, 1'b1, 7'd64));
        send_request(make_request(CMD_BURST, 8'h66, 1'b0, 7'd1));
        // A two-byte burst that runs one element past its announced length.
        send_request(make_request(CMD_BURST, 8'h11, 1'b1, 7'd2));
        send_request(make_request(CMD_BURST, 8'h22, 1'b0, 7'd2));
        send_request(make_request(CMD_BURST, 8'h33, 1'b0, 7'd2));
        // Drain the transmit ring, then once more to clear the active flag.
        repeat (6) send_request(make_request(CMD_TX_READY, 8'h00, 1'b0, 7'd1));
        send_request(make_request(CMD_RX_BYTE, 8'h5A, 1'b0, 7'd1));
        send_request(make_request(CMD_RX_FLUSH, 8'h00, 1'b0, 7'd1));
        send_request(make_request(CMD_PUT, 8'hAA, 1'b0, 7'd1));
        send_request(make_request(CMD_RESET, 8'h00, 1'b0, 7'd1));
        send_request(make_request(CMD_READ, 8'h00, 1'b0, 7'd1));

        // Fill each ring past full, then back the block up behind a stalled receiver.
        run_segment(FILL_RX, 80);
        run_segment(FILL_TX, 80);
        hold_request = 1'b1;
        run_segment(MIXED, 40);
        wait_drained();
        run_segment(DRAIN, 70);
        while (sent_items < 390) begin
            run_segment(mix_t'($urandom_range(0, 3)), $urandom_range(25, 60));
        end

        // Closing stretch at full rate on both sides.
        calm = 1'b1;
        run_segment(MIXED, 50);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (book.mismatches == 0 && book.due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
